// ----- rtl/gss_pkg.sv -----
`default_nettype none

package gss_pkg;

  // Operations of the shared iterative arithmetic unit.
  typedef enum logic [1:0] {
    OP_MUL,
    OP_DIV,
    OP_SQRT
  } mdu_op_t;

  // Request from the sequencer to the arithmetic unit.
  typedef struct packed {
    logic    start;
    mdu_op_t op;
  } mdu_req_t;

  // Register map of the configuration port.
  localparam logic [2:0] CFG_GROUPS_ADDR = 3'h0;
  localparam int         CFG_GROUPS_W    = 6;
  localparam logic [CFG_GROUPS_W-1:0] CFG_GROUPS_RESET = 6'd32;

  // Q8.8 extremes used as the empty value of the minimum and maximum.
  localparam logic signed [15:0] Q88_MOST_POS = 16'sh7FFF;
  localparam logic signed [15:0] Q88_MOST_NEG = 16'sh8000;

  // 100 percent in Q8.8, so the Q8.8 deviation over the Q8.8 mean gives a Q8.8 percentage.
  localparam logic [14:0] CV_SCALE = 15'd25600;

endpackage

`default_nettype wire

// ----- rtl/gss_ram.sv -----
`default_nettype none

module gss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- rtl/gss_mdu.sv -----
`default_nettype none

module gss_mdu
  import gss_pkg::*;
#(
  parameter int W = 66
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire mdu_req_t     req,
  input  wire logic [W-1:0] a,
  input  wire logic [W-1:0] b,
  output logic      [W-1:0] result,
  output logic              done
);

  localparam int CW = $clog2(W + 1);

  logic          busy;
  mdu_op_t       op_r;
  logic [CW-1:0] cnt;
  logic [W:0]    acc;
  logic [W-1:0]  shreg;
  logic [W-1:0]  mcand;
  logic [W-1:0]  root;

  logic [W:0]    div_rs;
  logic          div_ge;
  logic [W:0]    sq_rs;
  logic [W:0]    sq_trial;
  logic          sq_ge;
  logic [CW-1:0] last_cnt;

  // Trial subtractions for the divide and the square root step.
  always_comb begin
    div_rs   = {acc[W-1:0], shreg[W-1]};
    div_ge   = div_rs >= {1'b0, mcand};
    sq_rs    = {acc[W-2:0], shreg[W-1:W-2]};
    sq_trial = {root[W-2:0], 2'b01};
    sq_ge    = sq_rs >= sq_trial;
    last_cnt = (op_r == OP_SQRT) ? CW'(W / 2 - 1) : CW'(W - 1);
  end

  // One bit of product or quotient, or one root digit, per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy  <= 1'b1;
        op_r  <= req.op;
        cnt   <= '0;
        acc   <= '0;
        root  <= '0;
        shreg <= (req.op == OP_MUL) ? b : a;
        mcand <= (req.op == OP_MUL) ? a : b;
      end else if (busy) begin
        case (op_r)
          OP_MUL: begin
            if (shreg[0]) begin
              acc <= acc + {1'b0, mcand};
            end
            mcand <= {mcand[W-2:0], 1'b0};
            shreg <= {1'b0, shreg[W-1:1]};
          end
          OP_DIV: begin
            acc   <= div_ge ? (div_rs - {1'b0, mcand}) : div_rs;
            shreg <= {shreg[W-2:0], div_ge};
          end
          OP_SQRT: begin
            acc   <= sq_ge ? (sq_rs - sq_trial) : sq_rs;
            root  <= {root[W-2:0], sq_ge};
            shreg <= {shreg[W-3:0], 2'b00};
          end
          default: begin
            acc <= acc;
          end
        endcase
        cnt <= cnt + 1'b1;
        if (cnt == last_cnt) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Result of the finished operation.
  always_comb begin
    case (op_r)
      OP_MUL:  result = acc[W-1:0];
      OP_DIV:  result = shreg;
      OP_SQRT: result = root;
      default: result = shreg;
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/grouped_summary_statistics.sv -----
// Grouped summary statistics over a stream of signed Q8.8 samples.
// Input requests arrive on s_tvalid/s_tready/s_tdata/s_tuser. s_tuser is the
// kind: 0 adds a sample to its group, 1 finishes the batch. For a sample, the
// store entry is read when the request is accepted and the updated entry is
// written in the next cycle, after which s_tready returns. A skipped sample
// (missing value or group id out of range) is dropped and s_tready stays high.
// A finish request produces one summary per group in use on m_tvalid/m_tready,
// with m_tlast on the final group, and then empties the store at once.
// Each summary runs through one shared bit-serial multiply, divide and root unit
// of width W = 2*(COUNT_BITS+17). An empty group goes from the store read straight
// to the output, a single sample group computes only the mean, and a larger group
// adds the variance products, variance, root and, for a nonzero mean, the cv. The
// output register lets the next summary be computed while one waits; the sequencer
// holds when m_tready stays low and a new summary is ready. Reset empties the store,
// sets groups_in_use to 32 and drops any pending output. groups_in_use is written
// over the APB port at byte address 0; the user must write it only while the block
// is idle, unenforced by the block; values outside 1..MAX_GROUPS are clamped.
`default_nettype none

module grouped_summary_statistics
  import gss_pkg::*;
#(
  parameter int MAX_GROUPS = 32,
  parameter int COUNT_BITS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  // Configuration port.
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [2:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic      [31:0]  prdata,
  output logic              pready,
  // Input requests.
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // [7:0] group_id, [23:8] sample, [24] is_missing
  input  wire logic [31:0]  s_tdata,
  // [0] kind
  input  wire logic         s_tuser,
  // Summaries.
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // [5:0] group_number, [21:6] sample_count, [37:22] mean_value,
  // [53:38] std_dev, [69:54] min_value, [85:70] max_value,
  // [117:86] coeff_variation
  output logic [119:0]      m_tdata,
  // [0] mean_valid, [1] sd_valid, [2] cv_valid
  output logic [2:0]        m_tuser,
  output logic              m_tlast
);

  localparam int GW    = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int SUM_W = COUNT_BITS + 17;
  localparam int SQ_W  = COUNT_BITS + 32;
  localparam int EW    = COUNT_BITS + SUM_W + SQ_W + 32;
  localparam int W     = 2 * SUM_W;
  localparam int O_SUM = COUNT_BITS;
  localparam int O_SQ  = O_SUM + SUM_W;
  localparam int O_MIN = O_SQ + SQ_W;
  localparam int O_MAX = O_MIN + 16;

  typedef enum logic [3:0] {
    S_IDLE, S_UPD, F_RD, F_LD, F_MEAN, F_P, F_Q, F_D, F_VAR, F_SQRT, F_CV, F_EMIT
  } state_t;

  state_t state;

  // Configuration register and its port.
  logic [CFG_GROUPS_W-1:0] groups_in_use;

  assign pready = 1'b1;
  assign prdata = (paddr == CFG_GROUPS_ADDR) ? {26'd0, groups_in_use} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      groups_in_use <= CFG_GROUPS_RESET;
    end else if (psel && penable && pwrite && pready && paddr == CFG_GROUPS_ADDR) begin
      groups_in_use <= pwdata[CFG_GROUPS_W-1:0];
    end
  end

  // Number of groups in use, clamped to 1..MAX_GROUPS.
  logic [6:0] ng;
  always_comb begin
    if (groups_in_use == '0) begin
      ng = 7'd1;
    end else if ({1'b0, groups_in_use} > 7'(MAX_GROUPS)) begin
      ng = 7'(MAX_GROUPS);
    end else begin
      ng = {1'b0, groups_in_use};
    end
  end

  // Input fields.
  logic [7:0]         in_group;
  logic signed [15:0] in_sample;
  logic               in_missing;
  logic               sample_ok;
  logic [GW-1:0]      in_idx;
  logic [7:0]         in_idx_full;

  always_comb begin
    in_group    = s_tdata[7:0];
    in_sample   = s_tdata[23:8];
    in_missing  = s_tdata[24];
    sample_ok   = !in_missing && in_group != 8'd0 && in_group <= {1'b0, ng};
    in_idx_full = in_group - 8'd1;
    in_idx      = in_idx_full[GW-1:0];
  end

  assign s_tready = (state == S_IDLE);

  // Store of the per-group accumulators.
  logic [MAX_GROUPS-1:0] valid;
  logic [GW-1:0]         idx_r;
  logic [GW-1:0]         g;
  logic signed [15:0]    v_r;
  logic [31:0]           sqv_r;
  logic                  ram_we;
  logic [GW-1:0]         ram_raddr;
  logic [EW-1:0]         ram_wdata;
  logic [EW-1:0]         ram_rdata;

  gss_ram #(
    .WIDTH (EW),
    .DEPTH (MAX_GROUPS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx_r),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ram_raddr = (state == S_IDLE) ? in_idx : g;

  // Entry as read, with never-written entries taking their empty values.
  logic [GW-1:0]            rd_idx;
  logic                     ent_valid;
  logic [COUNT_BITS-1:0]    e_count;
  logic signed [SUM_W-1:0]  e_sum;
  logic [SQ_W-1:0]          e_sq;
  logic signed [15:0]       e_min;
  logic signed [15:0]       e_max;

  always_comb begin
    rd_idx    = (state == S_UPD) ? idx_r : g;
    ent_valid = valid[rd_idx];
    if (ent_valid) begin
      e_count = ram_rdata[COUNT_BITS-1:0];
      e_sum   = ram_rdata[O_SQ-1:O_SUM];
      e_sq    = ram_rdata[O_MIN-1:O_SQ];
      e_min   = ram_rdata[O_MAX-1:O_MIN];
      e_max   = ram_rdata[EW-1:O_MAX];
    end else begin
      e_count = '0;
      e_sum   = '0;
      e_sq    = '0;
      e_min   = Q88_MOST_POS;
      e_max   = Q88_MOST_NEG;
    end
  end

  // Read-modify-write of one entry; a full count drops the sample.
  logic               upd_ok;
  logic signed [15:0] new_min;
  logic signed [15:0] new_max;

  always_comb begin
    upd_ok    = (e_count != '1);
    new_min   = (v_r < e_min) ? v_r : e_min;
    new_max   = (v_r > e_max) ? v_r : e_max;
    ram_we    = (state == S_UPD) && upd_ok;
    ram_wdata = {new_max, new_min, e_sq + SQ_W'(sqv_r), e_sum + SUM_W'(v_r),
                 e_count + 1'b1};
  end

  // Working registers of the summary being computed.
  logic [COUNT_BITS-1:0]   c_r;
  logic signed [SUM_W-1:0] s_r;
  logic [SQ_W-1:0]         sq_r;
  logic signed [15:0]      mn_r;
  logic signed [15:0]      mx_r;
  logic signed [15:0]      mean_r;
  logic [15:0]             sd_r;
  logic signed [31:0]      cv_r;
  logic [W-1:0]            prod_p;
  logic [W-1:0]            prod_q;
  logic                    launched;

  logic [SUM_W-1:0]        abs_s;
  logic [15:0]             abs_mean;
  logic [30:0]             cv_num;
  logic                    sd_ok;
  logic                    mean_ok;
  logic [6:0]              g_next;
  logic                    last_g;
  logic [COUNT_BITS+15:0]  c_ext;
  logic [15:0]             c_sat;

  always_comb begin
    abs_s    = s_r[SUM_W-1] ? SUM_W'(-s_r) : SUM_W'(s_r);
    abs_mean = mean_r[15] ? 16'(-mean_r) : 16'(mean_r);
    cv_num   = 31'(sd_r * CV_SCALE);
    mean_ok  = (c_r != '0);
    sd_ok    = (c_r > COUNT_BITS'(1));
    g_next   = 7'(g) + 7'd1;
    last_g   = (g_next == ng);
    c_ext    = (COUNT_BITS + 16)'(c_r);
    c_sat    = (c_ext > (COUNT_BITS + 16)'(16'hFFFF)) ? 16'hFFFF : c_ext[15:0];
  end

  // Operand selection for the shared arithmetic unit.
  mdu_req_t     mdu_req;
  logic [W-1:0] mdu_a;
  logic [W-1:0] mdu_b;
  logic [W-1:0] mdu_res;
  logic         mdu_done;
  logic         op_state;

  always_comb begin
    mdu_a    = '0;
    mdu_b    = '0;
    mdu_req.op = OP_MUL;
    op_state = 1'b1;
    case (state)
      F_MEAN: begin
        mdu_a = W'(abs_s);
        mdu_b = W'(c_r);
        mdu_req.op = OP_DIV;
      end
      F_P: begin
        mdu_a = W'(c_r);
        mdu_b = W'(sq_r);
      end
      F_Q: begin
        mdu_a = W'(abs_s);
        mdu_b = W'(abs_s);
      end
      F_D: begin
        mdu_a = W'(c_r);
        mdu_b = W'(c_r - 1'b1);
      end
      F_VAR: begin
        mdu_a = prod_p;
        mdu_b = prod_q;
        mdu_req.op = OP_DIV;
      end
      F_SQRT: begin
        mdu_a = prod_p;
        mdu_req.op = OP_SQRT;
      end
      F_CV: begin
        mdu_a = W'(cv_num);
        mdu_b = W'(abs_mean);
        mdu_req.op = OP_DIV;
      end
      default: begin
        op_state = 1'b0;
      end
    endcase
    mdu_req.start = op_state && !launched;
  end

  gss_mdu #(
    .W (W)
  ) u_mdu (
    .clk    (clk),
    .rst    (rst),
    .req    (mdu_req),
    .a      (mdu_a),
    .b      (mdu_b),
    .result (mdu_res),
    .done   (mdu_done)
  );

  // Output register fields.
  logic [5:0]         o_group;
  logic [15:0]        o_count;
  logic signed [15:0] o_mean;
  logic [15:0]        o_sd;
  logic signed [15:0] o_min;
  logic signed [15:0] o_max;
  logic signed [31:0] o_cv;

  assign m_tdata = {2'b00, o_cv, o_max, o_min, o_sd, o_mean, o_count, o_group};

  // A finished summary enters the output register once it is free or being taken.
  logic emit_load;
  assign emit_load = (state == F_EMIT) && (!m_tvalid || m_tready);

  // Sequencer, store valid bits and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      valid    <= '0;
      launched <= 1'b0;
      g        <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (emit_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (op_state) begin
        launched <= !mdu_done;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            if (s_tuser) begin
              g     <= '0;
              state <= F_RD;
            end else if (sample_ok) begin
              idx_r <= in_idx;
              v_r   <= in_sample;
              sqv_r <= 32'(in_sample * in_sample);
              state <= S_UPD;
            end
          end
        end
        S_UPD: begin
          if (upd_ok) begin
            valid[idx_r] <= 1'b1;
          end
          state <= S_IDLE;
        end
        F_RD: begin
          state <= F_LD;
        end
        F_LD: begin
          c_r    <= e_count;
          s_r    <= e_sum;
          sq_r   <= e_sq;
          mn_r   <= e_min;
          mx_r   <= e_max;
          mean_r <= '0;
          sd_r   <= '0;
          cv_r   <= '0;
          state  <= (e_count != '0) ? F_MEAN : F_EMIT;
        end
        F_MEAN: begin
          if (mdu_done) begin
            mean_r <= s_r[SUM_W-1] ? -16'(mdu_res) : 16'(mdu_res);
            state  <= sd_ok ? F_P : F_EMIT;
          end
        end
        F_P: begin
          if (mdu_done) begin
            prod_p <= mdu_res;
            state  <= F_Q;
          end
        end
        F_Q: begin
          if (mdu_done) begin
            prod_q <= mdu_res;
            state  <= F_D;
          end
        end
        F_D: begin
          if (mdu_done) begin
            // Clamp a negative numerator to zero before the divide.
            prod_p <= (prod_p >= prod_q) ? (prod_p - prod_q) : '0;
            prod_q <= mdu_res;
            state  <= F_VAR;
          end
        end
        F_VAR: begin
          if (mdu_done) begin
            prod_p <= mdu_res;
            state  <= F_SQRT;
          end
        end
        F_SQRT: begin
          if (mdu_done) begin
            sd_r  <= (|mdu_res[W-1:16]) ? 16'hFFFF : mdu_res[15:0];
            state <= (mean_r != '0) ? F_CV : F_EMIT;
          end
        end
        F_CV: begin
          if (mdu_done) begin
            cv_r  <= mean_r[15] ? -32'(mdu_res) : 32'(mdu_res);
            state <= F_EMIT;
          end
        end
        F_EMIT: begin
          if (emit_load) begin
            o_group    <= g_next[5:0];
            o_count    <= c_sat;
            o_mean     <= mean_r;
            o_sd       <= sd_r;
            o_min      <= mean_ok ? mn_r : 16'sd0;
            o_max      <= mean_ok ? mx_r : 16'sd0;
            o_cv       <= cv_r;
            m_tuser[0] <= mean_ok;
            m_tuser[1] <= sd_ok;
            m_tuser[2] <= sd_ok && mean_r != '0;
            m_tlast    <= last_g;
            if (last_g) begin
              valid <= '0;
              g     <= '0;
              state <= S_IDLE;
            end else begin
              g     <= GW'(g_next);
              state <= F_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // An empty group reports zero mean, minimum and maximum.
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[37:22] == 16'd0 && m_tdata[85:54] == 32'd0)
    else $error("empty group summary carries nonzero values");

  // Validity flags nest: cv needs sd, sd needs mean.
  a_flag_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (!m_tuser[1] || m_tuser[0]) && (!m_tuser[2] || m_tuser[1]))
    else $error("validity flags out of order");

  // A deviation is only reported with at least two samples.
  a_sd_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tdata[21:6] >= 16'd2)
    else $error("deviation valid with fewer than two samples");

  // The store is empty right after a finish completes.
  a_cleared: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE && $past(state) == F_EMIT |-> valid == '0)
    else $error("store not cleared after finish");

endmodule

`default_nettype wire
